// ----- rtl/srsw_pkg.sv -----
// Shared types and constants of the selective-repeat send window.
// Field widths, command codes, register indexes and the result record.
// No dependencies.
`timescale 1ns / 1ps

package srsw_pkg;

    localparam int SEQ_W          = 16;
    localparam int CMD_W          = 2;
    localparam int TOTAL_W        = 16;
    localparam int WSIZE_W        = 7;
    localparam int SLID_W         = 7;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 16;
    localparam int RING_DEPTH_DEF = 64;
    localparam int SEQ_BITS_DEF   = 16;

    localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WSIZE = 1'b1;

    typedef struct packed {
        logic              accepted;
        logic [SEQ_W-1:0]  packet_seq;
        logic              resend_valid;
        logic [SEQ_W-1:0]  window_start;
        logic [SEQ_W-1:0]  window_end;
        logic [SLID_W-1:0] slid_count;
        logic              all_done;
    } t_result;

endpackage

// ----- rtl/srsw_ring.sv -----
// Acknowledge ring: one bit per outstanding slot, one write and one read port.
// Read data is registered. No dependencies.
`timescale 1ns / 1ps

module srsw_ring #(
    parameter int RING_DEPTH = 64,
    localparam int AW = $clog2(RING_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);

    logic r_mem [RING_DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/srsw_ctrl.sv -----
// Window sequencer: base/next sequence state, command decode and the slide walk
// over the acknowledge ring. Depends on srsw_pkg; drives the ports of srsw_ring.
`timescale 1ns / 1ps

module srsw_ctrl #(
    parameter int RING_DEPTH = 64,
    parameter int SEQ_BITS   = 16,
    localparam int AW = $clog2(RING_DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [srsw_pkg::TOTAL_W-1:0] i_total,
    input  logic [srsw_pkg::WSIZE_W-1:0] i_wsize,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [srsw_pkg::CMD_W-1:0]   i_command,
    input  logic [srsw_pkg::SEQ_W-1:0]   i_packet_number,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output srsw_pkg::t_result            o_res,
    output logic                         o_mem_we,
    output logic [AW-1:0]                o_mem_waddr,
    output logic                         o_mem_wdata,
    output logic                         o_mem_re,
    output logic [AW-1:0]                o_mem_raddr,
    input  logic                         i_mem_rdata
);

    import srsw_pkg::*;

    localparam int SW    = SEQ_BITS + 1;
    localparam int CW    = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = ((SEQ_BITS > CW) ? SEQ_BITS : CW) + 2;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHK   = 2'd1;
    localparam logic [1:0] S_SLIDE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [SW-1:0] r_base, n_base;
    logic [SW-1:0] r_next, n_next;
    logic [AW-1:0] r_bslot, n_bslot;
    logic [AW-1:0] r_nslot, n_nslot;
    logic [AW-1:0] r_pn_slot, n_pn_slot;
    logic          r_pn_base, n_pn_base;
    logic          r_acc, n_acc;
    logic          r_rv, n_rv;
    logic [SW-1:0] r_seq, n_seq;
    logic [CW-1:0] r_slid, n_slid;

    logic [SW-1:0]    total_eff;
    logic [SW-1:0]    pn_eff;
    logic [SW-1:0]    pn_off;
    logic [AW:0]      pn_sum;
    logic [AW-1:0]    pn_slot;
    logic [CW-1:0]    ws_eff;
    logic [SUM_W-1:0] wsum;
    logic [SUM_W-1:0] wend;
    logic             can_send;
    logic             in_range;
    logic [AW-1:0]    bslot_inc;
    logic [AW-1:0]    nslot_inc;
    logic [SW-1:0]    base_inc;

    assign total_eff = SW'(SEQ_BITS'(i_total));
    assign pn_eff    = SW'(SEQ_BITS'(i_packet_number));

    always_comb begin
        if (i_wsize == '0) begin
            ws_eff = CW'(1);
        end else if (int'(i_wsize) > RING_DEPTH) begin
            ws_eff = CW'(RING_DEPTH);
        end else begin
            ws_eff = CW'(i_wsize);
        end
    end

    assign wsum     = SUM_W'(r_base) + SUM_W'(ws_eff) - SUM_W'(1);
    assign wend     = (wsum > SUM_W'(total_eff)) ? SUM_W'(total_eff) : wsum;
    assign can_send = (SUM_W'(r_next) <= wend) && (r_next <= total_eff);
    assign in_range = (pn_eff >= r_base) && (pn_eff < r_next);

    // Offset from base is below the ring depth inside the outstanding range,
    // so one conditional subtract wraps the slot.
    assign pn_off  = pn_eff - r_base;
    assign pn_sum  = {1'b0, r_bslot} + (AW+1)'(pn_off);
    assign pn_slot = (pn_sum >= (AW+1)'(RING_DEPTH)) ?
                     AW'(pn_sum - (AW+1)'(RING_DEPTH)) : AW'(pn_sum);

    assign bslot_inc = (r_bslot == AW'(RING_DEPTH - 1)) ? '0 : r_bslot + 1'b1;
    assign nslot_inc = (r_nslot == AW'(RING_DEPTH - 1)) ? '0 : r_nslot + 1'b1;
    assign base_inc  = r_base + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_next      = r_next;
        n_bslot     = r_bslot;
        n_nslot     = r_nslot;
        n_pn_slot   = r_pn_slot;
        n_pn_base   = r_pn_base;
        n_acc       = r_acc;
        n_rv        = r_rv;
        n_seq       = r_seq;
        n_slid      = r_slid;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_bslot;
        o_mem_wdata = 1'b0;
        o_mem_re    = 1'b0;
        o_mem_raddr = bslot_inc;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_acc   = 1'b0;
                    n_rv    = 1'b0;
                    n_seq   = '0;
                    n_slid  = '0;
                    n_state = S_DONE;
                    unique case (i_command)
                        CMD_SEND: begin
                            if (can_send) begin
                                // clear the slot this packet takes over
                                n_acc       = 1'b1;
                                n_seq       = r_next;
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_nslot;
                                o_mem_wdata = 1'b0;
                                n_next      = r_next + 1'b1;
                                n_nslot     = nslot_inc;
                            end
                        end
                        CMD_ACK: begin
                            if (in_range) begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = pn_slot;
                                n_pn_slot   = pn_slot;
                                n_pn_base   = (pn_eff == r_base);
                                n_state     = S_CHK;
                            end
                        end
                        CMD_TIMEOUT: begin
                            if (r_base < r_next) begin
                                n_rv  = 1'b1;
                                n_seq = r_base;
                            end
                        end
                        CMD_NONE: begin
                        end
                    endcase
                end
            end
            S_CHK: begin
                n_state = S_DONE;
                if (!i_mem_rdata) begin
                    n_acc       = 1'b1;
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_pn_slot;
                    if (!r_pn_base) begin
                        o_mem_wdata = 1'b1;
                    end else begin
                        // acking the base: clear its slot and pass it in one step
                        o_mem_wdata = 1'b0;
                        n_base      = base_inc;
                        n_bslot     = bslot_inc;
                        n_slid      = CW'(1);
                        if (base_inc < r_next) begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = bslot_inc;
                            n_state     = S_SLIDE;
                        end
                    end
                end
            end
            S_SLIDE: begin
                n_state = S_DONE;
                if (i_mem_rdata) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_bslot;
                    o_mem_wdata = 1'b0;
                    n_base      = base_inc;
                    n_bslot     = bslot_inc;
                    n_slid      = r_slid + 1'b1;
                    if (base_inc < r_next) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = bslot_inc;
                        n_state     = S_SLIDE;
                    end
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base  <= SW'(1);
            r_next  <= SW'(1);
            r_bslot <= AW'(1);
            r_nslot <= AW'(1);
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_next  <= n_next;
            r_bslot <= n_bslot;
            r_nslot <= n_nslot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pn_slot <= n_pn_slot;
        r_pn_base <= n_pn_base;
        r_acc     <= n_acc;
        r_rv      <= n_rv;
        r_seq     <= n_seq;
        r_slid    <= n_slid;
    end

    assign o_res.accepted     = r_acc;
    assign o_res.packet_seq   = SEQ_W'(r_seq[SEQ_BITS-1:0]);
    assign o_res.resend_valid = r_rv;
    assign o_res.window_start = SEQ_W'(r_base[SEQ_BITS-1:0]);
    assign o_res.window_end   = SEQ_W'(wend[SEQ_BITS-1:0]);
    assign o_res.slid_count   = SLID_W'(r_slid);
    assign o_res.all_done     = (r_base > total_eff);

`ifndef SYNTH
    a_base_le_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base <= r_next)
        else $error("window base passed next sequence number");

    a_ring_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next - r_base) <= SW'(RING_DEPTH))
        else $error("outstanding packets exceed ring depth");

    a_slide_fed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SLIDE) |-> ($past(o_mem_re) && (r_slid != '0)))
        else $error("slide step without a pending ring read");

    a_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_we && o_mem_re) |-> (o_mem_waddr != o_mem_raddr))
        else $error("ring read and write hit the same slot");
`endif

endmodule

// ----- rtl/selective_repeat_send_window.sv -----
// Top level of the selective-repeat send window: configuration registers,
// result output register, sequencer and acknowledge ring. Depends on srsw_pkg,
// srsw_ctrl and srsw_ring.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one command per transaction:
//   send next, acknowledgement with packet number, or retransmit timeout.
//   Output channel (o_out_valid / i_out_ready) returns exactly one result per
//   command, in order. Configuration writes (i_cfg_we) set the packet total and
//   the window size; issue them only while the block is idle.
// Sequencing:
//   Send, timeout, the unused code and a stray ack go from acceptance straight
//   to the result state. An ack in range reads its ring slot in a check state,
//   then, if it acked the base and more remain outstanding, walks on in a slide state.
//   The base walks past acked slots one per cycle through the single read port.
//   One command is in flight at a time; the next can be accepted in the cycle
//   after the previous result moves into the output register.
// Reset: base, next sequence and configuration return to one, output to empty.
//   Ring slots are written by each send before any read, so no clearing pass.
// Stall: a result waits in the output register while i_out_ready is low; one
//   further command may complete behind it, then input acceptance stops.
`timescale 1ns / 1ps

module selective_repeat_send_window #(
    parameter int RING_DEPTH = srsw_pkg::RING_DEPTH_DEF,
    parameter int SEQ_BITS   = srsw_pkg::SEQ_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [srsw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srsw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [srsw_pkg::CMD_W-1:0]      i_command,
    input  logic [srsw_pkg::SEQ_W-1:0]      i_packet_number,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_accepted,
    output logic [srsw_pkg::SEQ_W-1:0]      o_packet_seq,
    output logic                            o_resend_valid,
    output logic [srsw_pkg::SEQ_W-1:0]      o_window_start,
    output logic [srsw_pkg::SEQ_W-1:0]      o_window_end,
    output logic [srsw_pkg::SLID_W-1:0]     o_slid_count,
    output logic                            o_all_done
);

    import srsw_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);

    logic [TOTAL_W-1:0] r_total;
    logic [WSIZE_W-1:0] r_wsize;
    t_result            r_out;
    logic               r_out_valid;

    t_result            res;
    logic               res_valid;
    logic               res_ready;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic               mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic               mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_W'(1);
            r_wsize <= WSIZE_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TOTAL: r_total <= TOTAL_W'(i_cfg_data);
                CFG_WSIZE: r_wsize <= i_cfg_data[WSIZE_W-1:0];
            endcase
        end
    end

    // take a new result whenever the output register is empty or draining
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    srsw_ctrl #(
        .RING_DEPTH (RING_DEPTH),
        .SEQ_BITS   (SEQ_BITS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_total         (r_total),
        .i_wsize         (r_wsize),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_packet_number (i_packet_number),
        .o_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .o_res           (res),
        .o_mem_we        (mem_we),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .o_mem_re        (mem_re),
        .o_mem_raddr     (mem_raddr),
        .i_mem_rdata     (mem_rdata)
    );

    srsw_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_out.accepted;
    assign o_packet_seq   = r_out.packet_seq;
    assign o_resend_valid = r_out.resend_valid;
    assign o_window_start = r_out.window_start;
    assign o_window_end   = r_out.window_end;
    assign o_slid_count   = r_out.slid_count;
    assign o_all_done     = r_out.all_done;

endmodule

// ----- tb/selective_repeat_send_window_tb.sv -----
// Self-checking testbench for the selective-repeat send window.
// Drives directed and random command traffic, predicts every result in-line.
// Depends on srsw_pkg and selective_repeat_send_window.
`timescale 1ns / 1ps

module selective_repeat_send_window_tb;

    import srsw_pkg::*;

    localparam int RING = RING_DEPTH_DEF;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [15:0]          value;
        logic [CMD_W-1:0]     cmd;
        bit                   pinned;
        t_result              want;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [CMD_W-1:0]      i_command;
    logic [SEQ_W-1:0]      i_packet_number;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_accepted;
    logic [SEQ_W-1:0]      o_packet_seq;
    logic                  o_resend_valid;
    logic [SEQ_W-1:0]      o_window_start;
    logic [SEQ_W-1:0]      o_window_end;
    logic [SLID_W-1:0]     o_slid_count;
    logic                  o_all_done;

    // Mirror of the sender window
    bit          acked_slot [RING];
    bit [16:0]   base_num  = 17'd1;
    bit [16:0]   next_num  = 17'd1;
    bit [15:0]   total_reg = 16'd1;
    bit [6:0]    wsize_reg = 7'd1;

    t_result     due_reports [$];
    t_dir_row    plan [$];

    int          mismatch_count = 0;
    int          commands_sent  = 0;
    int          sends_admitted = 0;
    int          acks_matched   = 0;
    int          resends_found  = 0;
    int          widest_slide   = 0;
    bit          steady         = 1'b0;
    bit          holdoff_armed  = 1'b0;
    bit          holdoff_spent  = 1'b0;
    int          holdoff_left   = 0;

    selective_repeat_send_window dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_packet_number (i_packet_number),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_accepted      (o_accepted),
        .o_packet_seq    (o_packet_seq),
        .o_resend_valid  (o_resend_valid),
        .o_window_start  (o_window_start),
        .o_window_end    (o_window_end),
        .o_slid_count    (o_slid_count),
        .o_all_done      (o_all_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Timed out at %0t", $time);
        $display("Some tests failed");
        $finish;
    end

    function automatic bit [16:0] window_limit();
        bit [6:0]  span;
        bit [17:0] reach;
        span = (wsize_reg == 7'd0) ? 7'd1 : (wsize_reg > RING) ? 7'(RING) : wsize_reg;
        reach = {1'b0, base_num} + 18'(span) - 18'd1;
        if (reach > 18'(total_reg)) reach = 18'(total_reg);
        return reach[16:0];
    endfunction

    // Apply one command to the mirror and return the report it yields
    function automatic t_result compute_window_report(logic [CMD_W-1:0] cmd,
                                                      logic [15:0] pn);
        t_result   rep;
        int        slid;
        bit [16:0] lim;
        rep  = '0;
        slid = 0;
        case (cmd)
            CMD_SEND: begin
                if (next_num <= window_limit() && next_num <= total_reg) begin
                    rep.accepted   = 1'b1;
                    rep.packet_seq = next_num[15:0];
                    acked_slot[next_num % RING] = 1'b0;
                    next_num++;
                end
            end
            CMD_ACK: begin
                if (pn >= base_num && pn < next_num && !acked_slot[pn % RING]) begin
                    rep.accepted = 1'b1;
                    acked_slot[pn % RING] = 1'b1;
                    // slide past every contiguous acked slot, clearing as we go
                    while (base_num < next_num && acked_slot[base_num % RING]) begin
                        acked_slot[base_num % RING] = 1'b0;
                        base_num++;
                        slid++;
                    end
                end
            end
            CMD_TIMEOUT: begin
                if (base_num < next_num) begin
                    rep.resend_valid = 1'b1;
                    rep.packet_seq   = base_num[15:0];
                end
            end
            default: ;
        endcase
        lim = window_limit();
        rep.window_start = base_num[15:0];
        rep.window_end   = lim[15:0];
        rep.slid_count   = slid[SLID_W-1:0];
        rep.all_done     = (base_num > total_reg);
        return rep;
    endfunction

    function automatic t_result report(int acc, int seq, int rv, int ws,
                                       int we, int slid, int done);
        t_result rep;
        rep.accepted     = 1'(acc);
        rep.packet_seq   = 16'(seq);
        rep.resend_valid = 1'(rv);
        rep.window_start = 16'(ws);
        rep.window_end   = 16'(we);
        rep.slid_count   = 7'(slid);
        rep.all_done     = 1'(done);
        return rep;
    endfunction

    function automatic t_dir_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        t_dir_row row;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.value   = data;
        row.cmd     = CMD_NONE;
        row.pinned  = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    function automatic t_dir_row cmd_row(logic [CMD_W-1:0] cmd, logic [15:0] pn);
        t_dir_row row;
        row.is_cfg  = 1'b0;
        row.reg_idx = CFG_TOTAL;
        row.value   = pn;
        row.cmd     = cmd;
        row.pinned  = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    function automatic t_dir_row pinned_row(logic [CMD_W-1:0] cmd, logic [15:0] pn,
                                            t_result want);
        t_dir_row row;
        row = cmd_row(cmd, pn);
        row.pinned = 1'b1;
        row.want   = want;
        return row;
    endfunction

    // Offer one command, hold it until taken, then log its expected report
    task automatic push_command(logic [CMD_W-1:0] cmd, logic [15:0] pn,
                                bit pinned, t_result want);
        t_result rep;
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 18) begin
            i_in_valid      <= 1'b0;
            i_command       <= CMD_W'($urandom);
            i_packet_number <= 16'($urandom);
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_packet_number <= pn;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        rep = compute_window_report(cmd, pn);
        due_reports.push_back(pinned ? want : rep);
        commands_sent++;
        if (cmd == CMD_SEND && rep.accepted) sends_admitted++;
        if (cmd == CMD_ACK && rep.accepted) acks_matched++;
        if (rep.resend_valid) resends_found++;
        if (int'(rep.slid_count) > widest_slide) widest_slide = int'(rep.slid_count);
    endtask

    // Drain the block, then write one register
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TOTAL) total_reg = data;
        else wsize_reg = data[6:0];
    endtask

    task automatic compare_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // Receiver: random stalls, one long hold-off, calm during steady stretches
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_armed && !holdoff_spent) begin
                holdoff_spent = 1'b1;
                holdoff_left  = 300;
            end
            if (holdoff_left != 0) begin
                i_out_ready <= 1'b0;
                holdoff_left--;
            end else if (steady) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 18);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_reports.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with none expected, expected nothing, got seq %0d",
                         $time, o_packet_seq);
            end else begin
                want = due_reports.pop_front();
                compare_field("accepted", 16'(want.accepted), 16'(o_accepted));
                compare_field("packet_seq", want.packet_seq, o_packet_seq);
                compare_field("resend_valid", 16'(want.resend_valid), 16'(o_resend_valid));
                compare_field("window_start", want.window_start, o_window_start);
                compare_field("window_end", want.window_end, o_window_end);
                compare_field("slid_count", 16'(want.slid_count), 16'(o_slid_count));
                compare_field("all_done", 16'(want.all_done), 16'(o_all_done));
            end
        end
    end

    initial begin
        logic [CMD_W-1:0] cmd;
        logic [15:0]      pn;
        bit [6:0]         ws;
        bit [16:0]        cap;
        int               roll;
        int               phase;
        int               round;
        int               k;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_TOTAL;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_command       = CMD_NONE;
        i_packet_number = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty window, unused code, single-packet transfer, zero
        // settings, oversized window, out-of-order and stray acks, lowered total
        plan.push_back(pinned_row(CMD_TIMEOUT, 16'h0000, report(0, 0, 0, 1, 1, 0, 0)));
        plan.push_back(pinned_row(CMD_NONE, 16'hFFFF, report(0, 0, 0, 1, 1, 0, 0)));
        plan.push_back(pinned_row(CMD_ACK, 16'h0001, report(0, 0, 0, 1, 1, 0, 0)));
        plan.push_back(pinned_row(CMD_SEND, 16'h0000, report(1, 1, 0, 1, 1, 0, 0)));
        plan.push_back(pinned_row(CMD_SEND, 16'hFFFF, report(0, 0, 0, 1, 1, 0, 0)));
        plan.push_back(pinned_row(CMD_TIMEOUT, 16'h0000, report(0, 1, 1, 1, 1, 0, 0)));
        plan.push_back(pinned_row(CMD_ACK, 16'h0001, report(1, 0, 0, 2, 1, 1, 1)));
        plan.push_back(pinned_row(CMD_ACK, 16'h0001, report(0, 0, 0, 2, 1, 0, 1)));
        plan.push_back(cfg_row(CFG_TOTAL, 16'd0));
        plan.push_back(cfg_row(CFG_WSIZE, 16'd0));
        plan.push_back(pinned_row(CMD_SEND, 16'h0000, report(0, 0, 0, 2, 0, 0, 1)));
        plan.push_back(cfg_row(CFG_TOTAL, 16'hFFFF));
        plan.push_back(cfg_row(CFG_WSIZE, 16'd127));
        plan.push_back(pinned_row(CMD_TIMEOUT, 16'h0000, report(0, 0, 0, 2, 65, 0, 0)));
        plan.push_back(cfg_row(CFG_WSIZE, 16'd3));
        plan.push_back(cmd_row(CMD_SEND, 16'h0000));
        plan.push_back(cmd_row(CMD_SEND, 16'h0000));
        plan.push_back(cmd_row(CMD_SEND, 16'h0000));
        plan.push_back(cmd_row(CMD_SEND, 16'h0000));
        plan.push_back(cmd_row(CMD_ACK, 16'd3));
        plan.push_back(cmd_row(CMD_ACK, 16'd5));
        plan.push_back(cmd_row(CMD_ACK, 16'd0));
        plan.push_back(cmd_row(CMD_ACK, 16'hFFFF));
        plan.push_back(cmd_row(CMD_TIMEOUT, 16'h0000));
        plan.push_back(cmd_row(CMD_ACK, 16'd2));
        plan.push_back(cfg_row(CFG_TOTAL, 16'd3));
        plan.push_back(cmd_row(CMD_SEND, 16'h0000));
        plan.push_back(cmd_row(CMD_ACK, 16'd4));

        foreach (plan[i]) begin
            if (plan[i].is_cfg) write_register(plan[i].reg_idx, plan[i].value);
            else push_command(plan[i].cmd, plan[i].value, plan[i].pinned, plan[i].want);
        end

        // Random phases: mostly legal traffic, some stray acks and unused codes
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0, 5:    ws = 7'd64;
                1:       ws = 7'd1;
                3:       ws = 7'd0;
                4:       ws = 7'($urandom_range(65, 127));
                7:       ws = 7'($urandom_range(1, 127));
                default: ws = 7'($urandom_range(2, 63));
            endcase
            if (phase == 3) begin
                // lower the total under the sent range
                cap = 17'(base_num - 1 + $urandom_range(0, next_num - base_num));
            end else if (phase == 6) begin
                cap = 17'h0FFFF;
            end else begin
                cap = 17'(base_num - 1 + $urandom_range(20, 200));
            end
            if (cap > 17'h0FFFF) cap = 17'h0FFFF;
            write_register(CFG_WSIZE, 16'(ws));
            write_register(CFG_TOTAL, cap[15:0]);
            steady = (phase == 5);
            if (phase == 2) holdoff_armed = 1'b1;
            repeat (110) begin
                roll = $urandom_range(99);
                pn   = 16'($urandom);
                if (roll < 40) begin
                    cmd = CMD_SEND;
                end else if (roll < 75 && next_num > base_num) begin
                    cmd = CMD_ACK;
                    pn  = 16'($urandom_range(base_num, next_num - 1));
                end else if (roll < 85) begin
                    cmd = CMD_TIMEOUT;
                end else if (roll < 95) begin
                    cmd = CMD_ACK;
                    if (roll[0]) pn = 16'(base_num + $urandom_range(0, 8) - 4);
                end else begin
                    cmd = CMD_NONE;
                end
                push_command(cmd, pn, 1'b0, '0);
            end
        end

        // Finish without idling: ack one full window in reverse so the base
        // slides across the whole ring at once, then ack the next one in order
        steady = 1'b1;
        write_register(CFG_TOTAL, 16'hFFFF);
        write_register(CFG_WSIZE, 16'd64);
        round = 0;
        while (round < 2) begin
            while (next_num <= window_limit() && next_num <= total_reg)
                push_command(CMD_SEND, 16'($urandom), 1'b0, '0);
            if (round % 2 == 0) begin
                for (k = next_num - 1; k >= int'(base_num); k--)
                    if (!acked_slot[k % RING]) push_command(CMD_ACK, 16'(k), 1'b0, '0);
            end else begin
                while (base_num < next_num)
                    push_command(CMD_ACK, base_num[15:0], 1'b0, '0);
            end
            round++;
        end
        push_command(CMD_TIMEOUT, 16'h0000, 1'b0, '0);
        push_command(CMD_SEND, 16'h0000, 1'b0, '0);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge i_clk);
        repeat (RING + 4) @(posedge i_clk);

        $display("Drove %0d commands: %0d sends admitted, %0d acks matched, %0d resends.",
                 commands_sent, sends_admitted, acks_matched, resends_found);
        $display("Widest slide %0d; base walked to %0d; %0d mismatches.",
                 widest_slide, base_num, mismatch_count);
        if (mismatch_count == 0 && due_reports.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- selective_repeat_send_window.f -----
rtl/srsw_pkg.sv
rtl/srsw_ring.sv
rtl/srsw_ctrl.sv
rtl/selective_repeat_send_window.sv
tb/selective_repeat_send_window_tb.sv
